// ===== hdl/dfq_pkg.sv =====
package dfq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_UNIQUE = 2'd0,
        OP_PLAIN  = 2'd1,
        OP_DEQ    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_DEQUEUED  = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode                    opcode;
        logic signed [DATA_W-1:0]   value_in;
    } t_in_req;

    typedef struct packed {
        t_status                    status;
        logic signed [DATA_W-1:0]   value_out;
        logic [COUNT_W-1:0]         count_out;
    } t_out_req;

endpackage

// ===== hdl/dedup_fifo_queue.sv =====
// Bounded FIFO of signed 32-bit values with optional duplicate rejection.
// Input channel (i_in_valid / o_in_ready / i_in_req) carries an opcode and a
// value: unique enqueue, plain enqueue, dequeue or clear. Every request gives
// exactly one response on the output channel (o_out_valid / i_out_ready /
// o_out_req) with a status, the dequeued value (zero otherwise) and the
// number of entries held afterwards.
// Entries live in a single-port-write, single-port-read RAM with a registered
// read. Requests are handled one at a time. A unique enqueue reads the stored
// entries one per cycle through the RAM read port until it finds a match or
// has read the last entry. The response reaches o_out_valid through the
// output register.
// An output register sits between the controller and the receiver: while it
// holds an untaken response the controller can still accept and process the
// next request, and then waits with its result until the register frees up.
// Reset empties the queue (head, tail and count to zero) and drops any
// pending response; RAM contents are not cleared and need no clearing pass.
module dedup_fifo_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dfq_pkg::t_in_req   i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dfq_pkg::t_out_req  o_out_req
);

    localparam int unsigned ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [dfq_pkg::DATA_W-1:0] wr_data;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [dfq_pkg::DATA_W-1:0] rd_data;
    logic                       res_valid;
    logic                       res_ready;
    dfq_pkg::t_out_req          res;

    logic                       r_out_valid, n_out_valid;
    dfq_pkg::t_out_req          r_out_req, n_out_req;

    dfq_ctrl #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    dfq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out_req   = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_req <= n_out_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

// ===== hdl/dfq_ram.sv =====
module dfq_ram #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [dfq_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [dfq_pkg::DATA_W-1:0] o_rd_data
);

    logic [dfq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [dfq_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/dfq_ctrl.sv =====
module dfq_ctrl #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4,
    parameter int unsigned CNT_W  = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  dfq_pkg::t_in_req           i_in_req,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output dfq_pkg::t_out_req          o_res,
    output logic                       o_wr_en,
    output logic [ADDR_W-1:0]          o_wr_addr,
    output logic [dfq_pkg::DATA_W-1:0] o_wr_data,
    output logic                       o_rd_en,
    output logic [ADDR_W-1:0]          o_rd_addr,
    input  logic [dfq_pkg::DATA_W-1:0] i_rd_data
);

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    dfq_pkg::t_state     r_state, n_state;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [ADDR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    dfq_pkg::t_opcode    r_op, n_op;
    logic [dfq_pkg::DATA_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]    r_scan_cnt, n_scan_cnt;
    logic [ADDR_W-1:0]   r_scan_ptr, n_scan_ptr;
    dfq_pkg::t_out_req   r_res, n_res;

    function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfq_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_value    <= n_value;
        r_scan_cnt <= n_scan_cnt;
        r_scan_ptr <= n_scan_ptr;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_op       = r_op;
        n_value    = r_value;
        n_scan_cnt = r_scan_cnt;
        n_scan_ptr = r_scan_ptr;
        n_res      = r_res;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_tail;
        o_wr_data   = r_value;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_head;

        case (r_state)
            dfq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_in_req.opcode;
                    n_value = i_in_req.value_in;
                    n_state = dfq_pkg::S_EXEC;
                    case (i_in_req.opcode)
                        dfq_pkg::OP_UNIQUE: begin
                            if (r_count != '0) begin
                                // first compare reads the oldest entry
                                o_rd_en    = 1'b1;
                                o_rd_addr  = r_head;
                                n_scan_cnt = '0;
                                n_scan_ptr = next_idx(r_head);
                                n_state    = dfq_pkg::S_SCAN;
                            end
                        end
                        dfq_pkg::OP_DEQ: begin
                            if (r_count != '0) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = r_head;
                                n_state   = dfq_pkg::S_DEQ;
                            end
                        end
                        default: begin
                            n_state = dfq_pkg::S_EXEC;
                        end
                    endcase
                end
            end
            dfq_pkg::S_SCAN: begin
                if (i_rd_data == r_value) begin
                    n_res.status    = dfq_pkg::ST_DUPLICATE;
                    n_res.value_out = '0;
                    n_res.count_out = dfq_pkg::COUNT_W'(r_count);
                    n_state         = dfq_pkg::S_DONE;
                end else if (r_scan_cnt == r_count - 1'b1) begin
                    n_state = dfq_pkg::S_EXEC;
                end else begin
                    o_rd_en    = 1'b1;
                    o_rd_addr  = r_scan_ptr;
                    n_scan_ptr = next_idx(r_scan_ptr);
                    n_scan_cnt = r_scan_cnt + 1'b1;
                end
            end
            dfq_pkg::S_DEQ: begin
                n_head          = next_idx(r_head);
                n_count         = r_count - 1'b1;
                n_res.status    = dfq_pkg::ST_DEQUEUED;
                n_res.value_out = i_rd_data;
                n_res.count_out = dfq_pkg::COUNT_W'(r_count - 1'b1);
                n_state         = dfq_pkg::S_DONE;
            end
            dfq_pkg::S_EXEC: begin
                n_state         = dfq_pkg::S_DONE;
                n_res.value_out = '0;
                case (r_op)
                    dfq_pkg::OP_UNIQUE, dfq_pkg::OP_PLAIN: begin
                        if (r_count == FULL_CNT) begin
                            n_res.status    = dfq_pkg::ST_FULL;
                            n_res.count_out = dfq_pkg::COUNT_W'(r_count);
                        end else begin
                            o_wr_en         = 1'b1;
                            n_tail          = next_idx(r_tail);
                            n_count         = r_count + 1'b1;
                            n_res.status    = dfq_pkg::ST_ENQUEUED;
                            n_res.count_out = dfq_pkg::COUNT_W'(r_count + 1'b1);
                        end
                    end
                    dfq_pkg::OP_DEQ: begin
                        // only reached with an empty queue
                        n_res.status    = dfq_pkg::ST_EMPTY;
                        n_res.count_out = dfq_pkg::COUNT_W'(r_count);
                    end
                    default: begin
                        n_head          = '0;
                        n_tail          = '0;
                        n_count         = '0;
                        n_res.status    = dfq_pkg::ST_CLEARED;
                        n_res.count_out = '0;
                    end
                endcase
            end
            dfq_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = dfq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dfq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== sim/dfq_checker.sv =====
module dfq_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  dfq_pkg::t_in_req   i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  dfq_pkg::t_out_req  i_out_req,
    output int                 o_fail_cnt,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the queue
    logic signed [dfq_pkg::DATA_W-1:0] shadow_entries [QUEUE_DEPTH];
    int unsigned                       shadow_head;
    int unsigned                       shadow_tail;
    int unsigned                       shadow_count;

    dfq_pkg::t_out_req expected_resp_q[$];

    task automatic report_mismatch(input string msg);
        o_fail_cnt++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Applies one request to the shadow queue and returns the response it must give.
    function automatic dfq_pkg::t_out_req apply_queue_op(input dfq_pkg::t_in_req req);
        dfq_pkg::t_out_req resp;
        int unsigned       slot;
        int unsigned       n;
        bit                found;
        resp  = '0;
        found = 1'b0;
        case (req.opcode)
            dfq_pkg::OP_UNIQUE, dfq_pkg::OP_PLAIN: begin
                if (req.opcode == dfq_pkg::OP_UNIQUE) begin
                    slot = shadow_head;
                    for (n = 0; n < shadow_count; n++) begin
                        if (shadow_entries[slot] == req.value_in) begin
                            found = 1'b1;
                        end
                        slot = (slot + 1) % QUEUE_DEPTH;
                    end
                end
                // duplicate check wins over full
                if (found) begin
                    resp.status = dfq_pkg::ST_DUPLICATE;
                end else if (shadow_count >= QUEUE_DEPTH) begin
                    resp.status = dfq_pkg::ST_FULL;
                end else begin
                    shadow_entries[shadow_tail] = req.value_in;
                    shadow_tail  = (shadow_tail + 1) % QUEUE_DEPTH;
                    shadow_count++;
                    resp.status = dfq_pkg::ST_ENQUEUED;
                end
            end
            dfq_pkg::OP_DEQ: begin
                if (shadow_count == 0) begin
                    resp.status = dfq_pkg::ST_EMPTY;
                end else begin
                    resp.value_out = shadow_entries[shadow_head];
                    shadow_head  = (shadow_head + 1) % QUEUE_DEPTH;
                    shadow_count--;
                    resp.status = dfq_pkg::ST_DEQUEUED;
                end
            end
            default: begin
                shadow_head  = 0;
                shadow_tail  = 0;
                shadow_count = 0;
                resp.status = dfq_pkg::ST_CLEARED;
            end
        endcase
        resp.count_out = dfq_pkg::COUNT_W'(shadow_count);
        return resp;
    endfunction

    always @(posedge i_clk) begin
        dfq_pkg::t_out_req want;
        if (!i_rst_n) begin
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_count = 0;
            expected_resp_q.delete();
        end else begin
            // response first: it can never belong to a request taken at this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_resp_q.size() == 0) begin
                    report_mismatch($sformatf("response with none pending: status %0d",
                                              i_out_req.status));
                end else begin
                    want = expected_resp_q.pop_front();
                    if (i_out_req.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_req.status, want.status));
                    end
                    if (i_out_req.value_out !== want.value_out) begin
                        report_mismatch($sformatf("value_out %h, expected %h",
                                                  i_out_req.value_out, want.value_out));
                    end
                    if (i_out_req.count_out !== want.count_out) begin
                        report_mismatch($sformatf("count_out %0d, expected %0d",
                                                  i_out_req.count_out, want.count_out));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_resp_q.push_back(apply_queue_op(i_in_req));
            end
        end
        o_pending <= expected_resp_q.size();
    end

endmodule

// ===== sim/tb_dedup_fifo_queue.sv =====
module tb_dedup_fifo_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUEUE_DEPTH    = 16;
    localparam int          RANDOM_ITEMS   = 1725;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_START     = 2500;
    localparam int          HOLD_CYCLES    = 500;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    dfq_pkg::t_in_req  i_in_req    = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    dfq_pkg::t_out_req o_out_req;

    int fail_cnt;
    int pending_cnt;
    int idle_cycles = 0;

    logic [dfq_pkg::DATA_W-1:0] value_pool [8];

    dedup_fifo_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    dfq_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_req   (o_out_req),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending_cnt)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic offer_request(input dfq_pkg::t_opcode op,
                                 input logic [dfq_pkg::DATA_W-1:0] val);
        i_in_valid <= 1'b1;
        i_in_req   <= '{opcode: op, value_in: val};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic [dfq_pkg::DATA_W-1:0] extreme_value();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // small pool so that unique enqueues hit duplicates often
    function automatic logic [dfq_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return value_pool[$urandom_range(0, 7)];
        end else if (r < 90) begin
            return $urandom();
        end
        return extreme_value();
    endfunction

    function automatic dfq_pkg::t_opcode pick_op(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 50) return dfq_pkg::OP_UNIQUE;
            if (r < 80) return dfq_pkg::OP_PLAIN;
            if (r < 98) return dfq_pkg::OP_DEQ;
        end else begin
            if (r < 20) return dfq_pkg::OP_UNIQUE;
            if (r < 30) return dfq_pkg::OP_PLAIN;
            if (r < 98) return dfq_pkg::OP_DEQ;
        end
        return dfq_pkg::OP_CLEAR;
    endfunction

    // stimulus and verdict
    initial begin
        int i;
        int k;
        int burst_left;
        int phase_left;
        bit filling;
        burst_left = 0;
        phase_left = 0;
        filling    = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_request(dfq_pkg::OP_DEQ, 32'h0000_0000);
        offer_request(dfq_pkg::OP_CLEAR, 32'hFFFF_FFFF);
        offer_request(dfq_pkg::OP_PLAIN, 32'h8000_0000);
        offer_request(dfq_pkg::OP_UNIQUE, 32'h7FFF_FFFF);
        offer_request(dfq_pkg::OP_UNIQUE, 32'h8000_0000);
        offer_request(dfq_pkg::OP_PLAIN, 32'h7FFF_FFFF);
        repeat (13) offer_request(dfq_pkg::OP_UNIQUE, $urandom());
        offer_request(dfq_pkg::OP_PLAIN, 32'h0000_0000);
        offer_request(dfq_pkg::OP_UNIQUE, 32'h0000_0001);
        offer_request(dfq_pkg::OP_UNIQUE, 32'h7FFF_FFFF);
        offer_request(dfq_pkg::OP_DEQ, 32'h0000_0000);
        offer_request(dfq_pkg::OP_CLEAR, 32'h0000_0000);
        // stale entries after a clear must not count as duplicates
        offer_request(dfq_pkg::OP_UNIQUE, 32'h7FFF_FFFF);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(10, 60);
                for (k = 0; k < 8; k++) begin
                    value_pool[k] = ($urandom_range(0, 3) == 0) ? extreme_value() : $urandom();
                end
            end
            phase_left--;
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                          : $urandom_range(1, 20);
            end
            burst_left--;
            offer_request(pick_op(filling), pick_value());
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // receiver: changing stall patterns, one long hold-off to back up the input
    initial begin
        int  cycle_cnt;
        int  mode_left;
        int  stall_mode;
        bit  held_off;
        cycle_cnt  = 0;
        mode_left  = 0;
        stall_mode = 0;
        held_off   = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held_off && cycle_cnt >= HOLD_START) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= $urandom_range(0, 1);
                    default: i_out_ready <= ($urandom_range(0, 7) == 0);
                endcase
                cycle_cnt++;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
